### src/crc8wd_pkg.sv
package crc8wd_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [1:0] DATA_BYTES = 2'd2;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_CRC_ERR    = 2'd1;
    localparam status_t ST_INCOMPLETE = 2'd2;
    localparam status_t ST_OVERFLOW   = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] word_value;
        logic [3:0]  word_index;
        status_t     status;
        logic        response_ok;
        logic        last_word;
    } result_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### src/crc8wd_in_reg.sv
module crc8wd_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  crc8wd_pkg::in_item_t s_item,
    input  logic                take,
    output logic                item_valid,
    output crc8wd_pkg::in_item_t item
);
    import crc8wd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### src/crc8wd_core.sv
module crc8wd_core #(
    parameter int MAX_WORDS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  crc8wd_pkg::in_item_t item,
    output logic                 res_valid,
    output crc8wd_pkg::result_t  res
);
    import crc8wd_pkg::*;

    localparam int CNT_W = ($clog2(MAX_WORDS + 1) > 4) ? $clog2(MAX_WORDS + 1) : 4;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WORDS);

    logic [1:0]       pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic [15:0]      held_reg, held_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             fail_reg, fail_next;
    logic             full;
    status_t          word_status;

    assign full = (count_reg >= CNT_MAX);

    always_comb begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        held_next   = held_reg;
        count_next  = count_reg;
        fail_next   = fail_reg;
        res_valid   = 1'b0;
        res         = '0;
        word_status = ST_OK;
        if (pos_reg < DATA_BYTES) begin
            pos_next  = pos_reg + 2'd1;
            crc_next  = crc8_step(crc_reg, item.rx_byte);
            held_next = {held_reg[7:0], item.rx_byte};
            if (item.final_byte) begin
                res_valid       = 1'b1;
                res.word_value  = '0;
                res.word_index  = count_reg[3:0];
                res.status      = ST_INCOMPLETE;
                res.response_ok = 1'b0;
                res.last_word   = 1'b1;
                pos_next        = '0;
                crc_next        = CRC_INIT;
                held_next       = '0;
                count_next      = '0;
                fail_next       = 1'b0;
            end
        end else begin
            if (full) begin
                word_status = ST_OVERFLOW;
            end else if (crc_reg != item.rx_byte) begin
                word_status = ST_CRC_ERR;
            end
            res_valid       = 1'b1;
            res.word_value  = held_reg;
            res.word_index  = count_reg[3:0];
            res.status      = word_status;
            res.response_ok = !(fail_reg || (word_status != ST_OK));
            res.last_word   = item.final_byte;
            pos_next        = '0;
            crc_next        = CRC_INIT;
            held_next       = '0;
            if (item.final_byte) begin
                count_next = '0;
                fail_next  = 1'b0;
            end else begin
                fail_next  = fail_reg || (word_status != ST_OK);
                count_next = full ? count_reg : count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            crc_reg   <= CRC_INIT;
            held_reg  <= '0;
            count_reg <= '0;
            fail_reg  <= 1'b0;
        end else if (advance) begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            held_reg  <= held_next;
            count_reg <= count_next;
            fail_reg  <= fail_next;
        end
    end

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= DATA_BYTES)
        else $error("byte position out of range");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("word count above limit");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res_valid && res.last_word |=>
            pos_reg == '0 && count_reg == '0 && !fail_reg && crc_reg == CRC_INIT)
        else $error("response state not cleared after last word");

    a_fail_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && fail_reg |-> !res.response_ok)
        else $error("response_ok set after a failed word");

endmodule

### src/crc8wd_out_reg.sv
module crc8wd_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  crc8wd_pkg::result_t res,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output crc8wd_pkg::result_t m_res
);
    import crc8wd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : ((valid_reg && m_ready) ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

### src/crc8_checked_word_deframer.sv
// Splits a sensor response byte stream into three-byte words (high byte, low byte,
// CRC-8 with polynomial 0x31 and initial value 0xFF) and gives one result per word with
// its status and a sticky response-ok flag; a response ending mid-word gives one result
// with the incomplete status. A byte is registered on input and evaluated
// combinationally into the output register, so one byte is accepted every cycle while
// the result side keeps up; a CRC byte goes through the input, then the output register.
// Holding m_ready low stalls the input once both of those registers are full.
module crc8_checked_word_deframer #(
    parameter int MAX_WORDS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_word_value,
    output logic [3:0]  m_word_index,
    output logic [1:0]  m_status,
    output logic        m_response_ok,
    output logic        m_last_word
);
    import crc8wd_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    logic     can_load;
    logic     res_valid;
    result_t  res;
    result_t  m_res;

    assign s_item.rx_byte    = s_rx_byte;
    assign s_item.final_byte = s_final_byte;
    assign advance           = item_valid && can_load;

    crc8wd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    crc8wd_core #(
        .MAX_WORDS (MAX_WORDS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    crc8wd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && res_valid),
        .res      (res),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_word_value  = m_res.word_value;
    assign m_word_index  = m_res.word_index;
    assign m_status      = m_res.status;
    assign m_response_ok = m_res.response_ok;
    assign m_last_word   = m_res.last_word;

endmodule
